### sv/srgb_pkg.sv
package srgb_pkg;

   localparam int COLOR_W = 24;
   localparam int SLOTS = 8;
   localparam int LED_W = 3;
   localparam int BITPOS_W = 5;
   localparam int TICK_W = 20;
   localparam int PERIOD_W = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = COLOR_W * SLOTS;
   localparam int RSP_DATA_W = 8;

   localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd125;
   localparam logic [PERIOD_W-1:0] ONE_HIGH_RST = 16'd80;
   localparam logic [PERIOD_W-1:0] ZERO_HIGH_RST = 16'd40;
   localparam logic [TICK_W-1:0] LATCH_LOW_RST = 20'd6000;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef enum logic [1:0] {
      REG_BIT_PERIOD = 2'd0,
      REG_ONE_HIGH = 2'd1,
      REG_ZERO_HIGH = 2'd2,
      REG_LATCH_LOW = 2'd3
   } srgb_reg_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_SEND = 2'd1,
      PH_LATCH = 2'd2
   } srgb_phase_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] bit_period;
      logic [PERIOD_W-1:0] one_high_time;
      logic [PERIOD_W-1:0] zero_high_time;
      logic [TICK_W-1:0] latch_low_time;
   } srgb_cfg_type;

   typedef struct packed {
      logic load_accepted;
      logic busy_res;
      logic line_level;
   } srgb_result_type;

endpackage

### sv/srgb_csr.sv
module srgb_csr
   import srgb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output srgb_cfg_type          cfg
);

   srgb_cfg_type cfg_ff;
   srgb_reg_type reg_sel;
   logic         wr_en;

   assign reg_sel = srgb_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period <= BIT_PERIOD_RST;
         cfg_ff.one_high_time <= ONE_HIGH_RST;
         cfg_ff.zero_high_time <= ZERO_HIGH_RST;
         cfg_ff.latch_low_time <= LATCH_LOW_RST;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_BIT_PERIOD: cfg_ff.bit_period <= csr_pwdata[PERIOD_W-1:0];
            REG_ONE_HIGH:   cfg_ff.one_high_time <= csr_pwdata[PERIOD_W-1:0];
            REG_ZERO_HIGH:  cfg_ff.zero_high_time <= csr_pwdata[PERIOD_W-1:0];
            REG_LATCH_LOW:  cfg_ff.latch_low_time <= csr_pwdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_BIT_PERIOD: csr_prdata = CSR_DATA_W'(cfg_ff.bit_period);
         REG_ONE_HIGH:   csr_prdata = CSR_DATA_W'(cfg_ff.one_high_time);
         REG_ZERO_HIGH:  csr_prdata = CSR_DATA_W'(cfg_ff.zero_high_time);
         REG_LATCH_LOW:  csr_prdata = CSR_DATA_W'(cfg_ff.latch_low_time);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

### sv/srgb_core.sv
module srgb_core
   import srgb_pkg::*;
#(
   parameter int LEDS_PER_COLUMN = 8,
   parameter int BITS_PER_LED = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  kind,
   input  logic [REQ_DATA_W-1:0] colors,
   input  logic                  last_column,
   input  srgb_cfg_type          cfg,
   output srgb_result_type       result
);

   localparam logic [LED_W-1:0] LED_LAST = LED_W'(LEDS_PER_COLUMN - 1);
   localparam logic [BITPOS_W-1:0] BIT_LAST = BITPOS_W'(BITS_PER_LED - 1);

   logic [COLOR_W-1:0]  store_ff [SLOTS];
   logic [LED_W-1:0]    led_ff, led_in;
   logic [BITPOS_W-1:0] bit_ff, bit_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic                odd_ff, odd_in;
   logic                frame_ff, frame_in;
   srgb_phase_type      phase_ff, phase_in;

   logic                load_take;
   logic [LED_W-1:0]    slot;
   logic [BITPOS_W-1:0] idx;
   logic [COLOR_W-1:0]  word;
   logic                cur_bit;
   logic [PERIOD_W-1:0] thr;
   logic [TICK_W-1:0]   tick_inc;

   assign slot = odd_ff ? led_ff : LED_LAST - led_ff;
   assign idx = BIT_LAST - bit_ff;
   assign word = store_ff[slot];
   assign cur_bit = (32'(idx) < COLOR_W) ? word[idx] : 1'b0;
   assign thr = cur_bit ? cfg.one_high_time : cfg.zero_high_time;
   assign tick_inc = tick_ff + 1'b1;

   always_comb begin
      led_in = led_ff;
      bit_in = bit_ff;
      tick_in = tick_ff;
      odd_in = odd_ff;
      frame_in = frame_ff;
      phase_in = phase_ff;
      load_take = 1'b0;
      result = '0;
      if (kind == KIND_LOAD) begin
         result.busy_res = 1'b1;
         if (phase_ff != PH_SEND && phase_ff != PH_LATCH) begin
            load_take = 1'b1;
            led_in = '0;
            bit_in = '0;
            tick_in = '0;
            frame_in = last_column;
            phase_in = PH_SEND;
            result.load_accepted = 1'b1;
         end
      end else begin
         unique case (phase_ff)
            PH_SEND: begin
               result.busy_res = 1'b1;
               result.line_level = tick_ff < TICK_W'(thr);
               tick_in = tick_inc;
               if (tick_inc >= TICK_W'(cfg.bit_period)) begin
                  tick_in = '0;
                  if (bit_ff == BIT_LAST) begin
                     bit_in = '0;
                     if (led_ff == LED_LAST) begin
                        led_in = '0;
                        odd_in = !odd_ff;
                        phase_in = frame_ff ? PH_LATCH : PH_IDLE;
                     end else begin
                        led_in = led_ff + 1'b1;
                     end
                  end else begin
                     bit_in = bit_ff + 1'b1;
                  end
               end
            end
            PH_LATCH: begin
               result.busy_res = 1'b1;
               tick_in = tick_inc;
               if (tick_inc >= cfg.latch_low_time) begin
                  tick_in = '0;
                  frame_in = 1'b0;
                  phase_in = PH_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff <= '0;
         bit_ff <= '0;
         tick_ff <= '0;
         odd_ff <= 1'b1;
         frame_ff <= 1'b0;
         phase_ff <= PH_IDLE;
      end else if (step) begin
         led_ff <= led_in;
         bit_ff <= bit_in;
         tick_ff <= tick_in;
         odd_ff <= odd_in;
         frame_ff <= frame_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && load_take) begin
         for (int s = 0; s < SLOTS; s++) begin
            store_ff[s] <= colors[s*COLOR_W +: COLOR_W];
         end
      end
   end

endmodule

### sv/serpentine_rgb_led_serializer.sv
// channel  direction  tdata (low bit up)                      tuser  tlast
// req      in         slot0_color .. slot7_color, 24b each     kind   last_column
// rsp      out        line_level, busy_res, load_accepted, pad -      -
// csr      apb        bit_period, one_high_time, zero_high_time, latch_low_time
//
// one beat in, one beat out; a beat can be taken every cycle req_tready is high, its result
// shows in the output register the cycle after
// the output register holds a stalled result while req_tready stays low; req_tready is high only
// when rsp_tready is high or the register is empty
// synchronous active-high reset: line idle, first column odd, timings at defaults
module serpentine_rgb_led_serializer
   import srgb_pkg::*;
#(
   parameter int LEDS_PER_COLUMN = 8,
   parameter int BITS_PER_LED = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // slot0_color .. slot7_color
   input  logic                  req_tuser,   // kind
   input  logic                  req_tlast,   // last_column
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // line_level, busy_res, load_accepted, zeros
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   srgb_cfg_type    cfg;
   srgb_result_type result;
   srgb_result_type rsp_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            step;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step = req_tvalid && req_tready;
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_tready);

   srgb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   srgb_core #(
      .LEDS_PER_COLUMN (LEDS_PER_COLUMN),
      .BITS_PER_LED    (BITS_PER_LED)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .kind        (req_tuser),
      .colors      (req_tdata),
      .last_column (req_tlast),
      .cfg         (cfg),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RSP_DATA_W'(rsp_ff);

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled with empty output register");

   a_level_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.line_level |-> rsp_ff.busy_res)
      else $error("line high outside a column");

   a_accept_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.load_accepted |-> rsp_ff.busy_res && !rsp_ff.line_level)
      else $error("accepted load with bad flags");

   a_back_to_back_load: assert property (@(posedge clock) disable iff (reset)
      step && result.load_accepted ##1 step && req_tuser == KIND_LOAD
      |-> !result.load_accepted)
      else $error("second load accepted while busy");

endmodule

### tb/tb_serpentine_rgb_led_serializer.sv
`timescale 1ns / 1ps

module tb_serpentine_rgb_led_serializer;
   import srgb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TICK_GUARD = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // slot0_color .. slot7_color
   logic                  req_tuser = 1'b0; // kind
   logic                  req_tlast = 1'b0; // last_column
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // line_level, busy_res, load_accepted, zeros
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predicted line driver state
   srgb_cfg_type        timing = '{BIT_PERIOD_RST, ONE_HIGH_RST, ZERO_HIGH_RST, LATCH_LOW_RST};
   logic [COLOR_W-1:0]  led_store [SLOTS];
   logic [LED_W-1:0]    led_slot = '0;
   logic [BITPOS_W-1:0] bit_idx = '0;
   logic [TICK_W-1:0]   tick_cnt = '0;
   logic                odd_col = 1'b1;
   srgb_phase_type      line_phase = PH_IDLE;
   logic                frame_end = 1'b0;

   srgb_result_type line_expect_q[$];
   int              err_count = 0;
   int unsigned     cycle_count = 0;
   int              stall_left = 0;
   bit              gaps_on = 1'b1;

   serpentine_rgb_led_serializer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_serpentine_rgb_led_serializer: errors");
         $finish;
      end
   end

   // receiver back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      srgb_result_type want;
      srgb_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = srgb_result_type'(rsp_tdata[2:0]);
         if (line_expect_q.size() == 0) begin
            $error("result beat with nothing expected: %0h", rsp_tdata);
            err_count++;
         end else begin
            want = line_expect_q.pop_front();
            if (got.line_level !== want.line_level) begin
               $error("line_level: expected %0b, got %0b", want.line_level, got.line_level);
               err_count++;
            end
            if (got.busy_res !== want.busy_res) begin
               $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
               err_count++;
            end
            if (got.load_accepted !== want.load_accepted) begin
               $error("load_accepted: expected %0b, got %0b", want.load_accepted,
                      got.load_accepted);
               err_count++;
            end
         end
      end
   end

   function automatic srgb_result_type led_line_step(input logic kind,
                                                     input logic [REQ_DATA_W-1:0] colours,
                                                     input logic last);
      srgb_result_type     r;
      logic [LED_W-1:0]    slot;
      logic [PERIOD_W-1:0] high_time;
      logic                bit_val;
      int                  idx;
      r = '0;
      if (kind == KIND_LOAD) begin
         r.busy_res = 1'b1;
         if (!(line_phase == PH_SEND || line_phase == PH_LATCH)) begin
            for (int s = 0; s < SLOTS; s++) led_store[s] = colours[s*COLOR_W +: COLOR_W];
            led_slot = '0;
            bit_idx = '0;
            tick_cnt = '0;
            frame_end = last;
            line_phase = PH_SEND;
            r.load_accepted = 1'b1;
         end
      end else if (line_phase == PH_SEND) begin
         // serpentine order: odd columns go up, even columns come down
         slot = odd_col ? led_slot : LED_W'(SLOTS - 1) - led_slot;
         idx = COLOR_W - 1 - int'(bit_idx);
         bit_val = (idx >= 0 && idx < COLOR_W) ? led_store[slot][idx] : 1'b0;
         high_time = bit_val ? timing.one_high_time : timing.zero_high_time;
         r.busy_res = 1'b1;
         r.line_level = (tick_cnt < TICK_W'(high_time));
         tick_cnt = tick_cnt + 1'b1;
         if (tick_cnt >= TICK_W'(timing.bit_period)) begin
            tick_cnt = '0;
            if (int'(bit_idx) + 1 >= COLOR_W) begin
               bit_idx = '0;
               if (int'(led_slot) + 1 >= SLOTS) begin
                  led_slot = '0;
                  odd_col = ~odd_col;
                  line_phase = frame_end ? PH_LATCH : PH_IDLE;
               end else begin
                  led_slot = led_slot + 1'b1;
               end
            end else begin
               bit_idx = bit_idx + 1'b1;
            end
         end
      end else if (line_phase == PH_LATCH) begin
         r.busy_res = 1'b1;
         tick_cnt = tick_cnt + 1'b1;
         if (tick_cnt >= timing.latch_low_time) begin
            tick_cnt = '0;
            frame_end = 1'b0;
            line_phase = PH_IDLE;
         end
      end
      return r;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] rand_column();
      logic [REQ_DATA_W-1:0] c;
      for (int s = 0; s < SLOTS; s++) c[s*COLOR_W +: COLOR_W] = COLOR_W'($urandom);
      return c;
   endfunction

   task automatic push_beat(input logic kind, input logic [REQ_DATA_W-1:0] colours,
                            input logic last);
      if (gaps_on && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= colours;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      line_expect_q.push_back(led_line_step(kind, colours, last));
   endtask

   task automatic send_tick();
      push_beat(KIND_TICK, rand_column(), 1'($urandom));
   endtask

   task automatic ticks_until(input srgb_phase_type target);
      int n;
      n = 0;
      while (line_phase != target && n < TICK_GUARD) begin
         send_tick();
         n++;
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (line_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input srgb_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      settle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_BIT_PERIOD: timing.bit_period = value[PERIOD_W-1:0];
         REG_ONE_HIGH: timing.one_high_time = value[PERIOD_W-1:0];
         REG_ZERO_HIGH: timing.zero_high_time = value[PERIOD_W-1:0];
         REG_LATCH_LOW: timing.latch_low_time = value[TICK_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_timing(input int period, input int one_hi, input int zero_hi,
                             input int latch);
      csr_write(REG_BIT_PERIOD, period);
      csr_write(REG_ONE_HIGH, one_hi);
      csr_write(REG_ZERO_HIGH, zero_hi);
      csr_write(REG_LATCH_LOW, latch);
   endtask

   // reset timings, refused loads while a column is going out
   task automatic test_default_timing();
      push_beat(KIND_LOAD, {SLOTS{24'hAAAAAA}}, 1'b0);
      repeat (12) send_tick();
      push_beat(KIND_LOAD, '1, 1'b1);
      push_beat(KIND_LOAD, '0, 1'b0);
      repeat (6) send_tick();
   endtask

   // one-tick bits, zero bits never high, shortest latch
   task automatic test_period_one();
      set_timing(1, 1, 0, 0);
      ticks_until(PH_IDLE);
      push_beat(KIND_LOAD, {24'h800001, 24'h400002, 24'h200004, 24'h100008,
                            24'h080010, 24'h040020, 24'h020040, 24'h010080}, 1'b1);
      ticks_until(PH_IDLE);
      repeat (3) send_tick();
   endtask

   // high time at or beyond the bit period holds the line high
   task automatic test_high_saturation();
      set_timing(1, 65535, 1, 1);
      push_beat(KIND_LOAD, rand_column(), 1'b1);
      ticks_until(PH_IDLE);
   endtask

   task automatic test_period_zero();
      set_timing(0, 0, 1, 2);
      push_beat(KIND_LOAD, '0, 1'b0);
      ticks_until(PH_IDLE);
   endtask

   // widest timings, then shortened while a column and a latch are in progress
   task automatic test_wide_timing();
      set_timing(65535, 32768, 65535, 1048575);
      push_beat(KIND_LOAD, rand_column(), 1'b1);
      repeat (40) send_tick();
      push_beat(KIND_LOAD, rand_column(), 1'b0);
      csr_write(REG_BIT_PERIOD, 1);
      ticks_until(PH_LATCH);
      repeat (30) send_tick();
      push_beat(KIND_LOAD, rand_column(), 1'b1);
      csr_write(REG_LATCH_LOW, 3);
      ticks_until(PH_IDLE);
   endtask

   task automatic test_random_frames();
      int period;
      int one_hi;
      int zero_hi;
      bit do_load;
      for (int round = 0; round < 3; round++) begin
         case ($urandom_range(0, 5))
            0: period = 0;
            1, 2, 3: period = 1;
            4: period = 2;
            default: period = 3;
         endcase
         one_hi = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, period + 1);
         zero_hi = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, period + 1);
         set_timing(period, one_hi, zero_hi, $urandom_range(0, 30));
         gaps_on = (round < 2);
         for (int n = 0; n < 70; n++) begin
            if (line_phase == PH_IDLE) do_load = ($urandom_range(0, 1) == 0);
            else do_load = ($urandom_range(0, 39) == 0);
            if (do_load) push_beat(KIND_LOAD, rand_column(), 1'($urandom));
            else send_tick();
         end
      end
   endtask

   initial begin
      for (int s = 0; s < SLOTS; s++) led_store[s] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_timing();
      test_period_one();
      test_high_saturation();
      test_period_zero();
      test_wide_timing();
      test_random_frames();
      settle();
      repeat (8) @(posedge clock);
      if (err_count == 0 && line_expect_q.size() == 0) begin
         $display("tb_serpentine_rgb_led_serializer: clean");
      end else begin
         $display("tb_serpentine_rgb_led_serializer: errors");
      end
      $finish;
   end

endmodule
